[hdl/mfs_pkg.sv]
package mfs_pkg;

  // Payload widths fixed by the channel definitions
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // Input action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_PUSH_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_POP_OK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic push;  // insert the pending value at its sorted place
    logic pop;   // shift the whole chain one cell toward the head
  } cell_cmd_t;

endpackage

[hdl/mfs_in_if.sv]
interface mfs_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [mfs_pkg::VAL_W-1:0]   value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

[hdl/mfs_out_if.sv]
interface mfs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mfs_pkg::VAL_W-1:0]   popped_value;
  logic        [mfs_pkg::STAT_W-1:0]  status;

  modport source (output valid, output popped_value, output status, input ready);
  modport sink   (input valid, input popped_value, input status, output ready);
endinterface

[hdl/max_frequency_stack.sv]
// Maximum-frequency stack on a chain of DEPTH cells kept sorted by level, highest level
// (newest on ties) at cell 0, so a pop always takes cell 0 and the chain shifts toward it.
// Pops, pops on an empty store and pushes on a full store finish in the accept cycle: one
// beat per cycle while results are taken. A push goes through a wait state and an insert
// state: each cell offers the level of the newest live copy of the pushed value, a registered
// OR tree of clog2(DEPTH) levels gathers it, and the insert state puts the entry in its place.
// In the cells, reset only clears the valid bits; there is no clearing pass.
module max_frequency_stack #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  mfs_in_if.sink    in_if,
  mfs_out_if.source out_if
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int LG = $clog2(DEPTH);
  localparam int CW = $clog2(LG + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WAIT   = 2'd1;
  localparam logic [1:0] S_INSERT = 2'd2;

  logic [1:0]                         state_r, state_nxt;
  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic [mfs_pkg::VAL_W-1:0]          push_val_r;
  logic                               out_vld_r;
  logic [mfs_pkg::VAL_W-1:0]          out_val_r;
  logic [mfs_pkg::STAT_W-1:0]         out_stat_r;

  logic                               out_free;
  logic                               acc;
  logic                               empty;
  logic                               full;
  logic [LW-1:0]                      root;
  logic [LW-1:0]                      push_level;
  mfs_pkg::cell_cmd_t                 cmd;

  logic                               vld_w   [DEPTH];
  logic                               top_w   [DEPTH];
  logic [mfs_pkg::VAL_W-1:0]          val_w   [DEPTH];
  logic [LW-1:0]                      lvl_w   [DEPTH];
  logic                               keep_w  [DEPTH];
  logic [LW-1:0]                      hit_w   [DEPTH];

  // Handshake
  assign out_free    = !out_vld_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && out_free;
  assign acc         = in_if.valid && in_if.ready;

  assign empty      = !vld_w[0];
  assign full       = vld_w[DEPTH-1];
  assign push_level = root + LW'(1);

  assign cmd.pop  = acc && (in_if.action == mfs_pkg::ACT_POP) && !empty;
  assign cmd.push = (state_r == S_INSERT) && out_free;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       l_keep, l_vld, l_top, r_vld, r_top;
    logic [mfs_pkg::VAL_W-1:0]  l_val, r_val;
    logic [LW-1:0]              l_lvl, r_lvl;

    if (i == 0) begin : g_head
      assign l_keep = 1'b1;
      assign l_vld  = 1'b0;
      assign l_top  = 1'b0;
      assign l_val  = '0;
      assign l_lvl  = '0;
    end else begin : g_mid
      assign l_keep = keep_w[i-1];
      assign l_vld  = vld_w[i-1];
      assign l_top  = top_w[i-1];
      assign l_val  = val_w[i-1];
      assign l_lvl  = lvl_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_vld = 1'b0;
      assign r_top = 1'b0;
      assign r_val = '0;
      assign r_lvl = '0;
    end else begin : g_body
      assign r_vld = vld_w[i+1];
      assign r_top = top_w[i+1];
      assign r_val = val_w[i+1];
      assign r_lvl = lvl_w[i+1];
    end

    mfs_cell #(.LW(LW)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .push_value  (push_val_r),
      .push_level  (push_level),
      .pop_value   (val_w[0]),
      .pop_level   (lvl_w[0]),
      .left_keep   (l_keep),
      .left_vld    (l_vld),
      .left_top    (l_top),
      .left_value  (l_val),
      .left_level  (l_lvl),
      .right_vld   (r_vld),
      .right_top   (r_top),
      .right_value (r_val),
      .right_level (r_lvl),
      .vld         (vld_w[i]),
      .top         (top_w[i]),
      .value       (val_w[i]),
      .level       (lvl_w[i]),
      .keep        (keep_w[i]),
      .hit_level   (hit_w[i])
    );
  end

  // Gather the level of the newest matching copy
  mfs_or_tree #(.N(DEPTH), .W(LW)) u_tree (
    .clk  (clk),
    .leaf (hit_w),
    .root (root)
  );

  // Sequence a push: wait out the tree, then insert
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (acc && (in_if.action == mfs_pkg::ACT_PUSH) && !full) begin
          state_nxt = S_WAIT;
          cnt_nxt   = CW'(LG);
        end
      end
      S_WAIT: begin
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Capture the pushed value for the duration of the push
  always_ff @(posedge clk) begin
    if (acc) begin
      push_val_r <= in_if.value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (acc && (in_if.action == mfs_pkg::ACT_POP)) begin
      out_vld_r <= 1'b1;
    end else if (acc && full) begin
      out_vld_r <= 1'b1;
    end else if (cmd.push) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (in_if.action == mfs_pkg::ACT_POP)) begin
      if (empty) begin
        out_val_r  <= '0;
        out_stat_r <= mfs_pkg::ST_EMPTY;
      end else begin
        out_val_r  <= val_w[0];
        out_stat_r <= mfs_pkg::ST_POP_OK;
      end
    end else if (acc && full) begin
      out_val_r  <= '0;
      out_stat_r <= mfs_pkg::ST_FULL;
    end else if (cmd.push) begin
      out_val_r  <= '0;
      out_stat_r <= mfs_pkg::ST_PUSH_OK;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.popped_value = out_val_r;
  assign out_if.status       = out_stat_r;

endmodule

[hdl/mfs_cell.sv]
module mfs_cell #(
  parameter int LW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mfs_pkg::cell_cmd_t         cmd,
  input  logic [mfs_pkg::VAL_W-1:0]  push_value,
  input  logic [LW-1:0]              push_level,
  input  logic [mfs_pkg::VAL_W-1:0]  pop_value,
  input  logic [LW-1:0]              pop_level,
  input  logic                       left_keep,
  input  logic                       left_vld,
  input  logic                       left_top,
  input  logic [mfs_pkg::VAL_W-1:0]  left_value,
  input  logic [LW-1:0]              left_level,
  input  logic                       right_vld,
  input  logic                       right_top,
  input  logic [mfs_pkg::VAL_W-1:0]  right_value,
  input  logic [LW-1:0]              right_level,
  output logic                       vld,
  output logic                       top,
  output logic [mfs_pkg::VAL_W-1:0]  value,
  output logic [LW-1:0]              level,
  output logic                       keep,
  output logic [LW-1:0]              hit_level
);

  logic                       vld_r, vld_nxt;
  logic                       top_r, top_nxt;
  logic [mfs_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic [LW-1:0]              level_r, level_nxt;
  logic [LW-1:0]              pop_below;
  logic                       own_match;
  logic                       left_match;
  logic                       right_promote;

  assign vld   = vld_r;
  assign top   = top_r;
  assign value = value_r;
  assign level = level_r;

  // Entries ranked above the new level stay in place on a push
  assign keep = vld_r && (level_r > push_level);

  // Report own level when this entry is the newest copy of the pushed value
  assign own_match = vld_r && (value_r == push_value);
  assign hit_level = (own_match && top_r) ? level_r : '0;

  // The copy one level below a popped entry becomes the newest of its value
  assign pop_below     = pop_level - LW'(1);
  assign left_match    = left_vld && (left_value == push_value);
  assign right_promote = right_vld && (right_value == pop_value) && (right_level == pop_below);

  // Hold, insert, shift right on push; shift left on pop
  always_comb begin
    vld_nxt   = vld_r;
    top_nxt   = top_r;
    value_nxt = value_r;
    level_nxt = level_r;
    if (cmd.pop) begin
      vld_nxt   = right_vld;
      top_nxt   = right_top || right_promote;
      value_nxt = right_value;
      level_nxt = right_level;
    end else if (cmd.push) begin
      if (keep) begin
        top_nxt = top_r && !own_match;
      end else if (left_keep) begin
        vld_nxt   = 1'b1;
        top_nxt   = 1'b1;
        value_nxt = push_value;
        level_nxt = push_level;
      end else begin
        vld_nxt   = left_vld;
        top_nxt   = left_top && !left_match;
        value_nxt = left_value;
        level_nxt = left_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    value_r <= value_nxt;
    level_r <= level_nxt;
  end

endmodule

[hdl/mfs_or_tree.sv]
module mfs_or_tree #(
  parameter int N = 64,
  parameter int W = 7
) (
  input  logic         clk,
  input  logic [W-1:0] leaf [N],
  output logic [W-1:0] root
);

  localparam int LG = $clog2(N);
  localparam int P  = 1 << LG;

  logic [W-1:0] leaf_pad [P];
  logic [W-1:0] node_r   [1:P-1];

  // Pad the leaf row to a power of two with zeros
  for (genvar i = 0; i < P; i++) begin : g_pad
    if (i < N) begin : g_real
      assign leaf_pad[i] = leaf[i];
    end else begin : g_zero
      assign leaf_pad[i] = '0;
    end
  end

  // Combine pairs, one register per tree level
  for (genvar j = 1; j < P; j++) begin : g_node
    if (2 * j >= P) begin : g_bottom
      always_ff @(posedge clk) begin
        node_r[j] <= leaf_pad[2*j-P] | leaf_pad[2*j+1-P];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node_r[j] <= node_r[2*j] | node_r[2*j+1];
      end
    end
  end

  assign root = node_r[1];

endmodule
